/* src/ccf_pkg.sv */
// ----------------------------------------------------------------------------
// ccf_pkg
// Shared constants, codes and types for the cascaded centered FIR over runs.
// ----------------------------------------------------------------------------
`default_nettype none

package ccf_pkg;

    localparam int MAX_HALF_TAPS = 15;
    localparam int SAMPLE_WIDTH  = 24;
    localparam int COEF_WIDTH    = 18;

    localparam int TAPS    = 2 * MAX_HALF_TAPS + 1;
    localparam int TAP_W   = $clog2(TAPS);
    localparam int HALF_W  = $clog2(MAX_HALF_TAPS + 1);
    localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W   = PROD_W + TAP_W;
    localparam int FRAC    = COEF_WIDTH - 1;
    localparam int CFG_W   = 4;
    localparam int CIDX_W  = 2;
    localparam int RUN_W   = 7;
    localparam int RUN_MAX = 127;
    localparam int CMP_W   = (TAP_W + 1 > RUN_W) ? TAP_W + 1 : RUN_W;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI   = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO   = ~SAT_HI;

    // word modes
    localparam logic [1:0] MODE_SAMPLE     = 2'd0;
    localparam logic [1:0] MODE_LP_COEF    = 2'd1;
    localparam logic [1:0] MODE_NOTCH_COEF = 2'd2;

    // config register indexes
    localparam logic [CIDX_W-1:0] REG_NOTCH_EN   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_NOTCH_HALF = 2'd1;
    localparam logic [CIDX_W-1:0] REG_LP_HALF    = 2'd2;

    typedef struct packed {
        logic                            clip;
        logic signed [SAMPLE_WIDTH-1:0]  value;
    } tap_t;

    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

    typedef struct packed {
        logic                            busy;
        logic                            clip;
        logic signed [SAMPLE_WIDTH-1:0]  value;
    } mac_status_t;

    function automatic logic [HALF_W-1:0] clamp_half(input logic [CFG_W-1:0] h);
        if (int'(h) > MAX_HALF_TAPS)
            return HALF_W'(MAX_HALF_TAPS);
        else
            return HALF_W'(h);
    endfunction

endpackage

`default_nettype wire

/* src/ccf_ram.sv */
// ----------------------------------------------------------------------------
// ccf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccf_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 31
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* src/ccf_delay_line.sv */
// ----------------------------------------------------------------------------
// ccf_delay_line
// Shift-register delay line with one registered read tap.
// ----------------------------------------------------------------------------
`default_nettype none

module ccf_delay_line
    import ccf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift_en,
    input  wire tap_t             shift_in,
    input  wire logic [TAP_W-1:0] rd_idx,
    output tap_t                  rd_data
);

    tap_t line_reg [TAPS];
    tap_t rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                line_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            line_reg[0] <= shift_in;
            for (int i = 1; i < TAPS; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= line_reg[rd_idx];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* src/ccf_mac.sv */
// ----------------------------------------------------------------------------
// ccf_mac
// Shared multiply-accumulate unit with round-half-up and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ccf_mac
    import ccf_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mac_ctrl_t                      ctrl,
    input  wire logic signed [COEF_WIDTH-1:0]   coef,
    input  wire logic signed [SAMPLE_WIDTH-1:0] smp,
    output mac_status_t                         status
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     pvld_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  rnd_sum;
    logic signed [ACC_W-1:0]  shifted;

    assign prod_next = coef * smp;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
            acc_next = '0;
        else if (pvld_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
            acc_reg  <= '0;
        end
        else
        begin
            pvld_reg <= ctrl.mul_en;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    // floor shift after half-LSB bias gives round half up
    assign rnd_sum = acc_reg + RND_BIAS;
    assign shifted = rnd_sum >>> FRAC;

    always_comb
    begin
        status.busy = pvld_reg;
        if (shifted > SAT_HI)
        begin
            status.clip  = 1'b1;
            status.value = SAT_HI[SAMPLE_WIDTH-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            status.clip  = 1'b1;
            status.value = SAT_LO[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            status.clip  = 1'b0;
            status.value = shifted[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

/* src/cascaded_centered_fir_over_runs.sv */
// ----------------------------------------------------------------------------
// cascaded_centered_fir_over_runs
// Optional centered notch FIR followed by a centered lowpass FIR over marked
// runs, computed on one shared multiply-accumulate unit.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    mode in_run run_start sample
//                                        coef_index coef_value
//   result    result_valid / result_stall filtered out_valid saturated
//   config    cfg_we                     cfg_index cfg_data
//
// A sample word is worked one MAC per tap, notch taps first when the notch
// is on, through the coefficient RAM read, product register and
// accumulator. item_stall is high while a sample is being worked. Reset
// clears both delay lines, run length and config; the coefficient RAMs are
// not cleared. A full, stalled result register holds the next sample's
// final rounding step until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_centered_fir_over_runs
    import ccf_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [CIDX_W-1:0]              cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_data,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic [1:0]                     mode,
    input  wire logic                           in_run,
    input  wire logic                           run_start,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic [TAP_W-1:0]               coef_index,
    input  wire logic signed [COEF_WIDTH-1:0]   coef_value,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      filtered,
    output logic                                out_valid,
    output logic                                saturated
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_NOTCH  = 3'd1;
    localparam logic [2:0] ST_NROUND = 3'd2;
    localparam logic [2:0] ST_LOW    = 3'd3;
    localparam logic [2:0] ST_LROUND = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic                    notch_en_reg;
    logic [CFG_W-1:0]        notch_half_reg;
    logic [CFG_W-1:0]        lp_half_reg;
    logic [RUN_W-1:0]        run_len_reg, run_len_next;
    logic [HALF_W-1:0]       nh_reg, nh_next;
    logic [HALF_W-1:0]       lh_reg, lh_next;
    logic                    win_ok_reg, win_ok_next;
    logic [TAP_W-1:0]        idx_reg, idx_next;
    logic                    done_reg, done_next;
    logic                    s1_vld_reg;
    logic                    any_clip_reg, any_clip_next;
    logic                    res_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] res_val_reg;
    logic                    res_ok_reg;
    logic                    res_sat_reg;
    logic                    load_res;

    logic                    accept;
    logic                    take_sample;
    logic                    coef_ok;
    logic                    issuing;
    logic                    phase_end;
    logic [HALF_W-1:0]       phase_half;
    logic [TAP_W-1:0]        span;
    logic [TAP_W-1:0]        tap_idx;
    logic [TAP_W-1:0]        sum_half;
    logic [CMP_W-1:0]        need_len;

    logic [COEF_WIDTH-1:0]   lp_rdata;
    logic [COEF_WIDTH-1:0]   notch_rdata;
    tap_t                    raw_rd;
    tap_t                    inter_rd;
    tap_t                    raw_in;
    tap_t                    inter_in;
    logic                    inter_shift;
    mac_ctrl_t               mac_ctrl;
    mac_status_t             mac_st;

    assign item_stall  = (state_reg != ST_IDLE);
    assign accept      = item_valid && !item_stall;
    assign take_sample = accept && (mode == MODE_SAMPLE);
    assign coef_ok     = ({1'b0, coef_index} < (TAP_W + 1)'(TAPS));

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notch_en_reg   <= 1'b0;
            notch_half_reg <= '0;
            lp_half_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NOTCH_EN:   notch_en_reg   <= cfg_data[0];
                REG_NOTCH_HALF: notch_half_reg <= cfg_data;
                REG_LP_HALF:    lp_half_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    // coefficient stores
    ccf_ram #(.WIDTH(COEF_WIDTH), .DEPTH(TAPS)) u_lp_coef (
        .clk   (clk),
        .we    (accept && (mode == MODE_LP_COEF) && coef_ok),
        .waddr (coef_index),
        .wdata (coef_value),
        .raddr (idx_reg),
        .rdata (lp_rdata)
    );

    ccf_ram #(.WIDTH(COEF_WIDTH), .DEPTH(TAPS)) u_notch_coef (
        .clk   (clk),
        .we    (accept && (mode == MODE_NOTCH_COEF) && coef_ok),
        .waddr (coef_index),
        .wdata (coef_value),
        .raddr (idx_reg),
        .rdata (notch_rdata)
    );

    // delay lines
    assign phase_half = (state_reg == ST_NOTCH) ? nh_reg : lh_reg;
    assign span       = TAP_W'({phase_half, 1'b0});
    assign tap_idx    = span - idx_reg;

    assign raw_in.clip  = 1'b0;
    assign raw_in.value = sample;

    always_comb
    begin
        if (state_reg == ST_NROUND)
        begin
            inter_shift    = 1'b1;
            inter_in.clip  = mac_st.clip;
            inter_in.value = mac_st.value;
        end
        else
        begin
            inter_shift    = take_sample && !notch_en_reg;
            inter_in.clip  = 1'b0;
            inter_in.value = sample;
        end
    end

    ccf_delay_line u_raw_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (take_sample),
        .shift_in (raw_in),
        .rd_idx   (tap_idx),
        .rd_data  (raw_rd)
    );

    ccf_delay_line u_inter_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (inter_shift),
        .shift_in (inter_in),
        .rd_idx   (tap_idx),
        .rd_data  (inter_rd)
    );

    // shared MAC
    assign mac_ctrl.clear  = take_sample || (state_reg == ST_NROUND);
    assign mac_ctrl.mul_en = s1_vld_reg;

    ccf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   ((state_reg == ST_NOTCH) ? $signed(notch_rdata) : $signed(lp_rdata)),
        .smp    ((state_reg == ST_NOTCH) ? raw_rd.value : inter_rd.value),
        .status (mac_st)
    );

    // sequencer
    assign issuing   = ((state_reg == ST_NOTCH) || (state_reg == ST_LOW)) && !done_reg;
    assign phase_end = ((state_reg == ST_NOTCH) || (state_reg == ST_LOW)) && done_reg
                       && !s1_vld_reg && !mac_st.busy;
    assign load_res  = (state_reg == ST_LROUND) && (!res_vld_reg || !result_stall);

    always_comb
    begin
        run_len_next = run_len_reg;
        if (!in_run)
            run_len_next = '0;
        else if (run_start)
            run_len_next = RUN_W'(1);
        else if (int'(run_len_reg) < RUN_MAX)
            run_len_next = run_len_reg + RUN_W'(1);
    end

    always_comb
    begin
        nh_next  = notch_en_reg ? clamp_half(notch_half_reg) : '0;
        lh_next  = clamp_half(lp_half_reg);
        sum_half = TAP_W'(nh_next) + TAP_W'(lh_next);
        need_len = CMP_W'({sum_half, 1'b1});
        win_ok_next = (CMP_W'(run_len_next) >= need_len);
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        done_next     = done_reg;
        any_clip_next = any_clip_reg;
        if (issuing)
        begin
            idx_next = idx_reg + TAP_W'(1);
            if (idx_reg == span)
                done_next = 1'b1;
        end
        if ((state_reg == ST_LOW) && s1_vld_reg && inter_rd.clip)
            any_clip_next = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_sample)
                begin
                    idx_next      = '0;
                    done_next     = 1'b0;
                    any_clip_next = 1'b0;
                    state_next    = notch_en_reg ? ST_NOTCH : ST_LOW;
                end
            end
            ST_NOTCH:
            begin
                if (phase_end)
                    state_next = ST_NROUND;
            end
            ST_NROUND:
            begin
                idx_next   = '0;
                done_next  = 1'b0;
                state_next = ST_LOW;
            end
            ST_LOW:
            begin
                if (phase_end)
                    state_next = ST_LROUND;
            end
            ST_LROUND:
            begin
                if (load_res)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            run_len_reg  <= '0;
            nh_reg       <= '0;
            lh_reg       <= '0;
            win_ok_reg   <= 1'b0;
            idx_reg      <= '0;
            done_reg     <= 1'b1;
            s1_vld_reg   <= 1'b0;
            any_clip_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            done_reg     <= done_next;
            s1_vld_reg   <= issuing;
            any_clip_reg <= any_clip_next;
            if (take_sample)
            begin
                run_len_reg <= run_len_next;
                nh_reg      <= nh_next;
                lh_reg      <= lh_next;
                win_ok_reg  <= win_ok_next;
            end
            if (load_res)
                res_vld_reg <= 1'b1;
            else if (!result_stall)
                res_vld_reg <= 1'b0;
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_ok_reg  <= win_ok_reg;
            res_val_reg <= win_ok_reg ? mac_st.value : '0;
            res_sat_reg <= win_ok_reg && (mac_st.clip || any_clip_reg);
        end
    end

    assign result_valid = res_vld_reg;
    assign filtered     = res_val_reg;
    assign out_valid    = res_ok_reg;
    assign saturated    = res_sat_reg;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for cascaded_centered_fir_over_runs. Every coefficient
// tap is loaded first. A directed table then covers the extremes, every word
// mode, ignored words and run resets. Random phases follow, one per register
// setting, and they mix well-formed runs with coefficient rewrites and noise.
// An in-bench model predicts each filtered word, and results are checked in
// order as they drain, under several sender and receiver stall patterns.
// ----------------------------------------------------------------------------

module testbench;
    import ccf_pkg::*;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         QUIET_LIMIT   = 4000;
    localparam int         PHASES        = 10;
    localparam int         PHASE_SAMPLES = 150;
    localparam longint     FS_HI = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint     FS_LO = -FS_HI - 1;

    typedef enum logic [1:0] { PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH } pace_t;

    typedef struct packed {
        logic [1:0]                     mode;
        logic                           in_run;
        logic                           run_start;
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic [TAP_W-1:0]               coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
    } word_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           valid;
        logic                           sat;
    } filt_t;

    typedef struct packed {
        word_t w;
        bit    typed;
        filt_t result;
    } row_t;

    typedef struct packed {
        logic             en;
        logic [CFG_W-1:0] notch_half;
        logic [CFG_W-1:0] lp_half;
        pace_t            pace;
    } phase_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           cfg_we       = 1'b0;
    logic [CIDX_W-1:0]              cfg_index    = '0;
    logic [CFG_W-1:0]               cfg_data     = '0;
    logic                           item_valid   = 1'b0;
    logic                           item_stall;
    logic [1:0]                     mode         = MODE_SAMPLE;
    logic                           in_run       = 1'b0;
    logic                           run_start    = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] sample       = '0;
    logic [TAP_W-1:0]               coef_index   = '0;
    logic signed [COEF_WIDTH-1:0]   coef_value   = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           out_valid;
    logic                           saturated;

    wire item_taken   = item_valid && !item_stall;
    wire result_taken = result_valid && !result_stall;

    // model state
    logic signed [SAMPLE_WIDTH-1:0] raw_taps   [TAPS];
    logic signed [SAMPLE_WIDTH-1:0] inter_taps [TAPS];
    logic                           inter_clip [TAPS];
    logic signed [COEF_WIDTH-1:0]   lp_coef    [TAPS];
    logic signed [COEF_WIDTH-1:0]   notch_coef [TAPS];
    int                             run_len;
    logic                           notch_on;
    logic [CFG_W-1:0]               notch_half;
    logic [CFG_W-1:0]               lp_half;

    filt_t pending_filtered [$];
    row_t  directed_rows [$];
    pace_t pace = PACE_FULL;
    int    mismatches = 0;
    int    results_seen = 0;
    filt_t want;

    cascaded_centered_fir_over_runs dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .in_run       (in_run),
        .run_start    (run_start),
        .sample       (sample),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .out_valid    (out_valid),
        .saturated    (saturated)
    );

    always #6 clk = ~clk;

    function automatic int rest_percent(bit receiver_side);
        if (pace == PACE_BOTH)
            return 15;
        if (pace == (receiver_side ? PACE_RECEIVER : PACE_SENDER))
            return 75;
        return 0;
    endfunction

    function automatic longint rand_value(int w);
        longint span;
        span = longint'(1) <<< (w - 1);
        case ($urandom_range(0, 19))
            0:             return -span;
            1:             return span - 1;
            2:             return 0;
            3, 4, 5, 6, 7: return longint'($urandom);
            default:       return longint'($urandom_range(0, 2 * (span >> 5))) - (span >> 5);
        endcase
    endfunction

    function automatic longint round_clip(input longint acc, output logic clip);
        longint v;
        v = (acc + (longint'(1) <<< (COEF_WIDTH - 2))) >>> (COEF_WIDTH - 1);
        clip = (v > FS_HI) || (v < FS_LO);
        if (v > FS_HI)
            v = FS_HI;
        if (v < FS_LO)
            v = FS_LO;
        return v;
    endfunction

    function automatic filt_t fir_cascade_step(input word_t w);
        filt_t  r;
        int     nh;
        int     lh;
        longint acc;
        longint v;
        logic   clip;
        logic   any_clip;
        for (int k = TAPS - 1; k > 0; k--)
        begin
            raw_taps[k]   = raw_taps[k - 1];
            inter_taps[k] = inter_taps[k - 1];
            inter_clip[k] = inter_clip[k - 1];
        end
        raw_taps[0] = w.sample;

        if (!w.in_run)
            run_len = 0;
        else if (w.run_start)
            run_len = 1;
        else if (run_len < RUN_MAX)
            run_len++;

        nh = !notch_on ? 0 :
             (int'(notch_half) > MAX_HALF_TAPS) ? MAX_HALF_TAPS : int'(notch_half);
        lh = (int'(lp_half) > MAX_HALF_TAPS) ? MAX_HALF_TAPS : int'(lp_half);

        if (notch_on)
        begin
            acc = 0;
            for (int j = 0; j <= 2 * nh; j++)
                acc += longint'($signed(notch_coef[j])) * longint'($signed(raw_taps[2 * nh - j]));
            v = round_clip(acc, clip);
        end
        else
        begin
            v    = longint'($signed(w.sample));
            clip = 1'b0;
        end
        inter_taps[0] = SAMPLE_WIDTH'(v);
        inter_clip[0] = clip;

        acc      = 0;
        any_clip = 1'b0;
        for (int j = 0; j <= 2 * lh; j++)
        begin
            acc += longint'($signed(lp_coef[j])) * longint'($signed(inter_taps[2 * lh - j]));
            any_clip |= inter_clip[2 * lh - j];
        end
        v = round_clip(acc, clip);

        r = '0;
        if (run_len >= 2 * (nh + lh) + 1)
        begin
            r.filtered = SAMPLE_WIDTH'(v);
            r.valid    = 1'b1;
            r.sat      = any_clip | clip;
        end
        return r;
    endfunction

    function automatic void add_row(logic [1:0] m, logic ir, logic rs, int x, int idx, int c,
                                    bit typed, int f, bit v, bit s);
        row_t row;
        row.w.mode          = m;
        row.w.in_run        = ir;
        row.w.run_start     = rs;
        row.w.sample        = SAMPLE_WIDTH'(x);
        row.w.coef_index    = TAP_W'(idx);
        row.w.coef_value    = COEF_WIDTH'(c);
        row.typed           = typed;
        row.result.filtered = SAMPLE_WIDTH'(f);
        row.result.valid    = v;
        row.result.sat      = s;
        directed_rows.push_back(row);
    endfunction

    task automatic note_mismatch(input string what, input longint got, input longint exp);
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, exp);
        mismatches++;
    endtask

    task automatic push_word(input word_t w, input bit typed, input filt_t given);
        filt_t r;
        while ($urandom_range(0, 99) < rest_percent(1'b0))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        mode       <= w.mode;
        in_run     <= w.in_run;
        run_start  <= w.run_start;
        sample     <= w.sample;
        coef_index <= w.coef_index;
        coef_value <= w.coef_value;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        case (w.mode)
            MODE_SAMPLE:
            begin
                r = fir_cascade_step(w);
                pending_filtered.push_back(typed ? given : r);
            end
            MODE_LP_COEF:
                if (w.coef_index < TAPS)
                    lp_coef[w.coef_index] = w.coef_value;
            MODE_NOTCH_COEF:
                if (w.coef_index < TAPS)
                    notch_coef[w.coef_index] = w.coef_value;
            default:
                ;
        endcase
    endtask

    task automatic hold_until_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_filtered.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        result_stall <= rst_n && ($urandom_range(0, 99) < rest_percent(1'b1));

    always @(posedge clk)
    begin
        if (rst_n && result_taken)
        begin
            if (pending_filtered.size() == 0)
                note_mismatch("unexpected word", longint'(filtered), 0);
            else
            begin
                want = pending_filtered.pop_front();
                if (filtered !== want.filtered)
                    note_mismatch("filtered", longint'(filtered), longint'(want.filtered));
                if (out_valid !== want.valid)
                    note_mismatch("out_valid", out_valid, want.valid);
                if (saturated !== want.sat)
                    note_mismatch("saturated", saturated, want.sat);
            end
            results_seen++;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || item_taken || result_taken)
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        word_t  w;
        filt_t  no_result;
        phase_t s;
        int     run_left;
        int     gap_left;
        int     win;
        int     sent;
        int     pick;
        bit     start_due;

        no_result = '0;
        for (int k = 0; k < TAPS; k++)
        begin
            raw_taps[k]   = '0;
            inter_taps[k] = '0;
            inter_clip[k] = 1'b0;
            lp_coef[k]    = '0;
            notch_coef[k] = '0;
        end
        run_len    = 0;
        notch_on   = 1'b0;
        notch_half = '0;
        lp_half    = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficient RAMs power up undefined: load every tap before any sample
        for (int k = 0; k < TAPS; k++)
        begin
            w            = '0;
            w.mode       = MODE_LP_COEF;
            w.coef_index = TAP_W'(k);
            w.coef_value = COEF_WIDTH'(rand_value(COEF_WIDTH));
            push_word(w, 1'b0, no_result);
            w.mode       = MODE_NOTCH_COEF;
            w.coef_value = COEF_WIDTH'(rand_value(COEF_WIDTH));
            push_word(w, 1'b0, no_result);
        end

        // reset settings: notch off, both half lengths zero, single lowpass tap
        add_row(MODE_LP_COEF,    0, 0, 0, 0, -131072, 0, 0, 0, 0);
        add_row(MODE_NOTCH_COEF, 0, 0, 0, 30, 131071, 0, 0, 0, 0);
        add_row(MODE_LP_COEF,    1, 1, -8388608, 31, 77, 0, 0, 0, 0);
        add_row(MODE_NOTCH_COEF, 0, 1, 8388607, 31, -5, 0, 0, 0, 0);
        add_row(MODE_UNUSED,     1, 1, -1, 31, -1, 0, 0, 0, 0);
        add_row(MODE_SAMPLE,     0, 0, 100, 0, 0, 1, 0, 0, 0);
        add_row(MODE_SAMPLE,     1, 1, -8388608, 0, 0, 1, 8388607, 1, 1);
        add_row(MODE_SAMPLE,     1, 0, 8388607, 31, -131072, 1, -8388607, 1, 0);
        add_row(MODE_SAMPLE,     1, 0, 0, 0, 0, 1, 0, 1, 0);
        add_row(MODE_SAMPLE,     1, 0, 1, 0, 0, 1, -1, 1, 0);
        add_row(MODE_SAMPLE,     1, 0, -1, 0, 0, 1, 1, 1, 0);
        add_row(MODE_SAMPLE,     0, 1, 555, 0, 0, 1, 0, 0, 0);
        add_row(MODE_SAMPLE,     1, 0, 42, 0, 0, 1, -42, 1, 0);
        add_row(MODE_LP_COEF,    0, 0, 0, 0, 65536, 0, 0, 0, 0);
        add_row(MODE_SAMPLE,     1, 0, 3, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SAMPLE,     1, 0, -3, 0, 0, 0, 0, 0, 0);
        add_row(MODE_LP_COEF,    0, 0, 0, 0, 131071, 0, 0, 0, 0);
        add_row(MODE_SAMPLE,     1, 0, 8388607, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SAMPLE,     1, 1, -8388608, 0, 0, 0, 0, 0, 0);
        add_row(MODE_UNUSED,     0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SAMPLE,     1, 0, 123456, 0, 0, 0, 0, 0, 0);

        foreach (directed_rows[i])
            push_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].result);

        for (int p = 0; p < PHASES; p++)
        begin
            hold_until_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);

            case (p)
                0:       s = '{1'b0, 4'd0, 4'd0, PACE_FULL};
                1:       s = '{1'b1, 4'd15, 4'd15, PACE_FULL};
                2:       s = '{1'b1, 4'd2, 4'd3, PACE_SENDER};
                3:       s = '{1'b0, 4'd9, 4'd15, PACE_RECEIVER};
                4:       s = '{1'b1, 4'd15, 4'd0, PACE_BOTH};
                5:       s = '{1'b1, 4'd0, 4'd0, PACE_SENDER};
                6:       s = '{1'b0, 4'd0, 4'd15, PACE_BOTH};
                default: s = '{1'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                               pace_t'($urandom_range(0, 3))};
            endcase

            cfg_we    <= 1'b1;
            cfg_index <= REG_NOTCH_EN;
            cfg_data  <= {(CFG_W - 1)'($urandom), s.en};
            @(posedge clk);
            cfg_index <= REG_NOTCH_HALF;
            cfg_data  <= s.notch_half;
            @(posedge clk);
            cfg_index <= REG_LP_HALF;
            cfg_data  <= s.lp_half;
            @(posedge clk);
            cfg_we     <= 1'b0;
            notch_on   = s.en;
            notch_half = s.notch_half;
            lp_half    = s.lp_half;
            pace       = s.pace;

            win       = 2 * ((s.en ? int'(s.notch_half) : 0) + int'(s.lp_half)) + 1;
            sent      = 0;
            run_left  = 0;
            gap_left  = 0;
            start_due = 1'b0;
            while (sent < PHASE_SAMPLES)
            begin
                if (sent == 40 || $urandom_range(0, 199) == 0)
                    hold_until_drained();

                w.in_run     = 1'($urandom);
                w.run_start  = 1'($urandom);
                w.sample     = SAMPLE_WIDTH'(rand_value(SAMPLE_WIDTH));
                w.coef_index = TAP_W'($urandom_range(0, 31));
                w.coef_value = COEF_WIDTH'(rand_value(COEF_WIDTH));
                pick = $urandom_range(0, 99);
                if (pick < 84)
                begin
                    w.mode = MODE_SAMPLE;
                    if (run_left == 0 && gap_left == 0)
                    begin
                        gap_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
                        run_left  = ($urandom_range(0, 9) < 7) ? win + $urandom_range(0, 120)
                                                               : $urandom_range(1, win + 3);
                        start_due = 1'b1;
                    end
                    if (gap_left > 0)
                    begin
                        w.in_run = 1'b0;
                        gap_left--;
                    end
                    else
                    begin
                        // occasional restart mid-run breaks the window
                        w.in_run    = 1'b1;
                        w.run_start = start_due || ($urandom_range(0, 60) == 0);
                        start_due   = 1'b0;
                        run_left--;
                    end
                    sent++;
                end
                else if (pick < 91)
                    w.mode = MODE_LP_COEF;
                else if (pick < 98)
                    w.mode = MODE_NOTCH_COEF;
                else
                    w.mode = MODE_UNUSED;
                push_word(w, 1'b0, no_result);
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
